@@ rtl/msp_pkg.sv @@
// Package for the message stream prevalidator.
// Holds widths, byte codes, classification types and the verdict codes.
// No dependencies.
package msp_pkg;

  localparam int COUNT_W     = 21;
  localparam int NEST_W      = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] MAX_BYTES_RESET = COUNT_W'(1024 * 1024);
  localparam logic [NEST_W-1:0]  NEST_MAX = {NEST_W{1'b1}};

  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] MASK_CONT   = 8'hC0;
  localparam logic [7:0] CODE_CONT   = 8'h80;
  localparam logic [7:0] MASK_LEAD2  = 8'hE0;
  localparam logic [7:0] CODE_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3  = 8'hF0;
  localparam logic [7:0] CODE_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4  = 8'hF8;
  localparam logic [7:0] CODE_LEAD4  = 8'hF0;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_OBRACE    = 8'h7B;
  localparam logic [7:0] CH_CBRACE    = 8'h7D;
  localparam logic [7:0] CH_OBRACK    = 8'h5B;
  localparam logic [7:0] CH_CBRACK    = 8'h5D;

  typedef enum logic [2:0] {
    U_ASCII,
    U_CONT,
    U_LEAD2,
    U_LEAD3,
    U_LEAD4,
    U_BAD
  } utf_cls_t;

  typedef enum logic [2:0] {
    J_OTHER,
    J_QUOTE,
    J_ESC,
    J_OBRACE,
    J_CBRACE,
    J_OBRACK,
    J_CBRACK
  } json_cls_t;

  typedef enum logic [1:0] {
    V_OK,
    V_SIZE,
    V_UTF8,
    V_JSON
  } verdict_t;

  typedef struct packed {
    logic      last;
    utf_cls_t  utf;
    json_cls_t json;
  } cls_t;

endpackage

@@ rtl/msp_front.sv @@
// Front stage: accepts message bytes and registers their byte class.
// Depends on msp_pkg.
module msp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  output logic          push,
  output msp_pkg::cls_t push_cls,
  input  logic          q_ready
);

  logic          fv_r;
  msp_pkg::cls_t cls_r;
  msp_pkg::cls_t cls_nxt;

  always_comb begin
    cls_nxt.last = in_last_byte;
    if (in_data_byte <= msp_pkg::ASCII_MAX) begin
      cls_nxt.utf = msp_pkg::U_ASCII;
    end else if ((in_data_byte & msp_pkg::MASK_CONT) == msp_pkg::CODE_CONT) begin
      cls_nxt.utf = msp_pkg::U_CONT;
    end else if ((in_data_byte & msp_pkg::MASK_LEAD2) == msp_pkg::CODE_LEAD2) begin
      cls_nxt.utf = msp_pkg::U_LEAD2;
    end else if ((in_data_byte & msp_pkg::MASK_LEAD3) == msp_pkg::CODE_LEAD3) begin
      cls_nxt.utf = msp_pkg::U_LEAD3;
    end else if ((in_data_byte & msp_pkg::MASK_LEAD4) == msp_pkg::CODE_LEAD4) begin
      cls_nxt.utf = msp_pkg::U_LEAD4;
    end else begin
      cls_nxt.utf = msp_pkg::U_BAD;
    end
    case (in_data_byte)
      msp_pkg::CH_QUOTE:     cls_nxt.json = msp_pkg::J_QUOTE;
      msp_pkg::CH_BACKSLASH: cls_nxt.json = msp_pkg::J_ESC;
      msp_pkg::CH_OBRACE:    cls_nxt.json = msp_pkg::J_OBRACE;
      msp_pkg::CH_CBRACE:    cls_nxt.json = msp_pkg::J_CBRACE;
      msp_pkg::CH_OBRACK:    cls_nxt.json = msp_pkg::J_OBRACK;
      msp_pkg::CH_CBRACK:    cls_nxt.json = msp_pkg::J_CBRACK;
      default:               cls_nxt.json = msp_pkg::J_OTHER;
    endcase
  end

  assign in_ready = !fv_r || q_ready;
  assign push     = fv_r && q_ready;
  assign push_cls = cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv_r <= 1'b1;
    end else if (push) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

@@ rtl/msp_queue.sv @@
// Short queue of classified bytes between the front and back stages.
// Depends on msp_pkg.
module msp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  msp_pkg::cls_t push_cls,
  output logic          q_ready,
  input  logic          pop,
  output msp_pkg::cls_t pop_cls,
  output logic          q_valid
);

  msp_pkg::cls_t                     mem_r [msp_pkg::QUEUE_DEPTH];
  logic [msp_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r;
  logic [msp_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r;
  logic [msp_pkg::QUEUE_CNT_W-1:0]   count_r;

  assign q_ready = count_r != msp_pkg::QUEUE_CNT_W'(msp_pkg::QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign pop_cls = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == msp_pkg::QUEUE_PTR_W'(msp_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == msp_pkg::QUEUE_PTR_W'(msp_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cls;
    end
  end

endmodule

@@ rtl/msp_back.sv @@
// Back stage: runs the size, UTF-8, bracket and string checks and holds the verdict.
// Depends on msp_pkg.
module msp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [msp_pkg::COUNT_W-1:0] cfg_wr_data,
  input  logic                        q_valid,
  input  msp_pkg::cls_t               pop_cls,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_verdict
);

  logic [msp_pkg::COUNT_W-1:0] max_r;
  logic [msp_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [1:0]                  cont_r, cont_nxt;
  logic                        ubad_r, ubad_nxt;
  logic                        quoted_r, quoted_nxt;
  logic                        esc_r, esc_nxt;
  logic [msp_pkg::NEST_W-1:0]  brace_r, brace_nxt;
  logic [msp_pkg::NEST_W-1:0]  brack_r, brack_nxt;
  logic                        sbad_r, sbad_nxt;
  logic                        ov_r;
  msp_pkg::verdict_t           verdict_r, verdict_nxt;

  assign pop         = q_valid && (!pop_cls.last || !ov_r || out_ready);
  assign out_valid   = ov_r;
  assign out_verdict = verdict_r;

  always_comb begin
    count_nxt  = (count_r != msp_pkg::COUNT_MAX) ? count_r + 1'b1 : count_r;
    cont_nxt   = cont_r;
    ubad_nxt   = ubad_r;
    quoted_nxt = quoted_r;
    esc_nxt    = esc_r;
    brace_nxt  = brace_r;
    brack_nxt  = brack_r;
    sbad_nxt   = sbad_r;

    if (cont_r != 2'd0) begin
      if (pop_cls.utf != msp_pkg::U_CONT) begin
        ubad_nxt = 1'b1;
      end
      cont_nxt = cont_r - 2'd1;
    end else begin
      case (pop_cls.utf)
        msp_pkg::U_ASCII: ;
        msp_pkg::U_LEAD2: cont_nxt = 2'd1;
        msp_pkg::U_LEAD3: cont_nxt = 2'd2;
        msp_pkg::U_LEAD4: cont_nxt = 2'd3;
        default:          ubad_nxt = 1'b1;
      endcase
    end

    if (esc_r) begin
      esc_nxt = 1'b0;
    end else if (quoted_r) begin
      if (pop_cls.json == msp_pkg::J_ESC) begin
        esc_nxt = 1'b1;
      end else if (pop_cls.json == msp_pkg::J_QUOTE) begin
        quoted_nxt = 1'b0;
      end
    end else begin
      case (pop_cls.json)
        msp_pkg::J_QUOTE: quoted_nxt = 1'b1;
        msp_pkg::J_OBRACE: begin
          if (brace_r == msp_pkg::NEST_MAX) sbad_nxt = 1'b1;
          else brace_nxt = brace_r + 1'b1;
        end
        msp_pkg::J_CBRACE: begin
          if (brace_r == '0) sbad_nxt = 1'b1;
          else brace_nxt = brace_r - 1'b1;
        end
        msp_pkg::J_OBRACK: begin
          if (brack_r == msp_pkg::NEST_MAX) sbad_nxt = 1'b1;
          else brack_nxt = brack_r + 1'b1;
        end
        msp_pkg::J_CBRACK: begin
          if (brack_r == '0) sbad_nxt = 1'b1;
          else brack_nxt = brack_r - 1'b1;
        end
        default: ;
      endcase
    end

    if (count_nxt > max_r) begin
      verdict_nxt = msp_pkg::V_SIZE;
    end else if (ubad_nxt || cont_nxt != 2'd0) begin
      verdict_nxt = msp_pkg::V_UTF8;
    end else if (sbad_nxt || brace_nxt != '0 || brack_nxt != '0 || quoted_nxt) begin
      verdict_nxt = msp_pkg::V_JSON;
    end else begin
      verdict_nxt = msp_pkg::V_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= msp_pkg::MAX_BYTES_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cont_r   <= 2'd0;
      ubad_r   <= 1'b0;
      quoted_r <= 1'b0;
      esc_r    <= 1'b0;
      brace_r  <= '0;
      brack_r  <= '0;
      sbad_r   <= 1'b0;
    end else if (pop) begin
      if (pop_cls.last) begin
        count_r  <= '0;
        cont_r   <= 2'd0;
        ubad_r   <= 1'b0;
        quoted_r <= 1'b0;
        esc_r    <= 1'b0;
        brace_r  <= '0;
        brack_r  <= '0;
        sbad_r   <= 1'b0;
      end else begin
        count_r  <= count_nxt;
        cont_r   <= cont_nxt;
        ubad_r   <= ubad_nxt;
        quoted_r <= quoted_nxt;
        esc_r    <= esc_nxt;
        brace_r  <= brace_nxt;
        brack_r  <= brack_nxt;
        sbad_r   <= sbad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (pop && pop_cls.last) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_cls.last) begin
      verdict_r <= verdict_nxt;
    end
  end

endmodule

@@ rtl/message_stream_prevalidator.sv @@
// Top level of the message stream prevalidator.
// Instantiates msp_front, msp_queue and msp_back; uses msp_pkg.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_data_byte[7:0], in_last_byte
// out       output     out_valid/out_ready  out_verdict[1:0]
// cfg       input      cfg_wr_en            cfg_wr_data[20:0]
//
// One byte is accepted every cycle while the queue has room; the verdict of a message
// reaches the verdict register after its last byte passes the front register and the queue.
// Reset is synchronous and clears all message state and sets the maximum to 1048576.
// A two-entry queue parts the front and back, so either side stalls on its own.
// A waiting verdict holds only last bytes back; other bytes keep flowing.
module message_stream_prevalidator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_verdict,
  input  logic                        cfg_wr_en,
  input  logic [msp_pkg::COUNT_W-1:0] cfg_wr_data
);

  logic          push;
  logic          q_ready;
  logic          q_valid;
  logic          pop;
  msp_pkg::cls_t push_cls;
  msp_pkg::cls_t pop_cls;

  msp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .push_cls     (push_cls),
    .q_ready      (q_ready)
  );

  msp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cls (push_cls),
    .q_ready  (q_ready),
    .pop      (pop),
    .pop_cls  (pop_cls),
    .q_valid  (q_valid)
  );

  msp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .pop_cls     (pop_cls),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_verdict (out_verdict)
  );

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready)
    else $error("queue written while full");

  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue read while empty");

  a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pop && pop_cls.last))
    else $error("verdict raised without a last byte");

  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && q_valid && pop_cls.last) |-> !pop)
    else $error("last byte consumed while verdict still pending");

endmodule
